>>> sv/dcs_pkg.sv
// dcs_pkg: shared types and constants of the darkest circle select block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dcs_pkg;

    // parameter defaults
    localparam int MAX_CIRCLES_DEF = 8;
    localparam int COORD_BITS_DEF  = 10;
    localparam int SUM_BITS_DEF    = 28;

    // fixed field widths
    localparam int SLOT_BITS = 3;
    localparam int PIX_BITS  = 8;
    localparam int RW_BITS   = 11;

    localparam logic [RW_BITS-1:0] RW_RESET = RW_BITS'(1024);

    // beat kind, carried on tuser
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_PIXEL = 1'b1
    } t_op;

    // pixel control traveling down the pipe
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [PIX_BITS-1:0] pix;
    } t_pix_ctl;

endpackage

>>> sv/dcs_front.sv
// dcs_front: row width register, circle table, loaded flags, raster counters
// and the input stage register. Depends on dcs_pkg.
`timescale 1ns / 1ps

module dcs_front import dcs_pkg::*; #(
    parameter int MAX_CIRCLES = MAX_CIRCLES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  logic                    i_op,
    input  logic [SLOT_BITS-1:0]    i_slot,
    input  logic [COORD_BITS-1:0]   i_cx,
    input  logic [COORD_BITS-1:0]   i_cy,
    input  logic [COORD_BITS-1:0]   i_rad,
    input  logic [PIX_BITS-1:0]     i_pix,
    input  logic                    i_last,
    input  logic                    i_cfg_valid,
    input  logic [RW_BITS-1:0]      i_cfg_data,
    output t_pix_ctl                o_ctl,
    output logic [MAX_CIRCLES-1:0]  o_mask,
    output logic [COORD_BITS-1:0]   o_col,
    output logic [COORD_BITS-1:0]   o_row,
    output logic [COORD_BITS-1:0]   o_cx  [MAX_CIRCLES],
    output logic [COORD_BITS-1:0]   o_cy  [MAX_CIRCLES],
    output logic [2*COORD_BITS-1:0] o_rsq [MAX_CIRCLES]
);

    localparam int SPAN = 1 << COORD_BITS;
    localparam int EW   = (COORD_BITS + 1 > RW_BITS) ? COORD_BITS + 1 : RW_BITS;

    logic [RW_BITS-1:0]      r_row_width;
    logic [COORD_BITS-1:0]   r_col, n_col;
    logic [COORD_BITS-1:0]   r_row, n_row;
    logic [MAX_CIRCLES-1:0]  r_loaded, n_loaded;
    t_pix_ctl                r_ctl, n_ctl;
    logic [COORD_BITS-1:0]   r_s1_col, r_s1_row;
    logic [MAX_CIRCLES-1:0]  r_s1_mask;
    logic [COORD_BITS-1:0]   r_cx  [MAX_CIRCLES];
    logic [COORD_BITS-1:0]   r_cy  [MAX_CIRCLES];
    logic [2*COORD_BITS-1:0] r_rsq [MAX_CIRCLES];

    logic                    w_acc, w_pix_acc, w_load_acc;
    logic [2*COORD_BITS-1:0] w_rsq;
    logic [EW-1:0]           w_rw, w_eff, w_col_inc;
    logic                    w_wrap;

    assign w_acc      = i_valid && i_adv;
    assign w_pix_acc  = w_acc && (t_op'(i_op) == OP_PIXEL);
    assign w_load_acc = w_acc && (t_op'(i_op) == OP_LOAD) && (int'(i_slot) < MAX_CIRCLES);

    // radius squared kept in the table
    assign w_rsq = {{COORD_BITS{1'b0}}, i_rad} * {{COORD_BITS{1'b0}}, i_rad};

    // effective row width: zero acts as one, clamp at coordinate span
    always_comb begin
        w_rw      = EW'(r_row_width);
        if (w_rw == '0) begin
            w_eff = EW'(1);
        end else if (w_rw > EW'(SPAN)) begin
            w_eff = EW'(SPAN);
        end else begin
            w_eff = w_rw;
        end
        w_col_inc = EW'(r_col) + EW'(1);
        w_wrap    = (w_col_inc >= w_eff);
    end

    always_comb begin
        n_col = w_wrap ? '0 : r_col + COORD_BITS'(1);
        n_row = w_wrap ? r_row + COORD_BITS'(1) : r_row;
        if (i_last) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_comb begin
        n_loaded = r_loaded;
        for (int i = 0; i < MAX_CIRCLES; i++) begin
            if (w_load_acc && int'(i_slot) == i) begin
                n_loaded[i] = 1'b1;
            end
        end
        if (w_pix_acc && i_last) begin
            n_loaded = '0;
        end
    end

    always_comb begin
        n_ctl.valid = w_pix_acc;
        n_ctl.last  = i_last;
        n_ctl.pix   = i_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= RW_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_loaded    <= '0;
            r_ctl       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_row_width <= i_cfg_data;
            end
            if (w_pix_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_loaded <= n_loaded;
            if (i_adv) begin
                r_ctl <= n_ctl;
            end
        end
    end

    // pixel position and loaded set as seen by this pixel
    always_ff @(posedge i_clk) begin
        if (w_pix_acc) begin
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_mask <= r_loaded;
        end
    end

    for (genvar i = 0; i < MAX_CIRCLES; i++) begin : g_tab
        always_ff @(posedge i_clk) begin
            if (w_load_acc && int'(i_slot) == i) begin
                r_cx[i]  <= i_cx;
                r_cy[i]  <= i_cy;
                r_rsq[i] <= w_rsq;
            end
        end
        assign o_cx[i]  = r_cx[i];
        assign o_cy[i]  = r_cy[i];
        assign o_rsq[i] = r_rsq[i];
    end

    assign o_ctl  = r_ctl;
    assign o_mask = r_s1_mask;
    assign o_col  = r_s1_col;
    assign o_row  = r_s1_row;

`ifndef ASSERT_OFF
    a_region_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pix_acc && i_last) |=> (r_col == '0 && r_row == '0 && r_loaded == '0))
        else $error("region state not cleared after last pixel");
`endif

endmodule

>>> sv/dcs_dist.sv
// dcs_dist: per-circle distance lanes; squares then the strict inside test,
// one register stage each. Depends on dcs_pkg.
`timescale 1ns / 1ps

module dcs_dist import dcs_pkg::*; #(
    parameter int MAX_CIRCLES = MAX_CIRCLES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  t_pix_ctl                i_ctl,
    input  logic [MAX_CIRCLES-1:0]  i_mask,
    input  logic [COORD_BITS-1:0]   i_col,
    input  logic [COORD_BITS-1:0]   i_row,
    input  logic [COORD_BITS-1:0]   i_cx  [MAX_CIRCLES],
    input  logic [COORD_BITS-1:0]   i_cy  [MAX_CIRCLES],
    input  logic [2*COORD_BITS-1:0] i_rsq [MAX_CIRCLES],
    output t_pix_ctl                o_ctl,
    output logic [MAX_CIRCLES-1:0]  o_mask,
    output logic                    o_hit [MAX_CIRCLES]
);

    localparam int QW = 2 * COORD_BITS;

    t_pix_ctl               r_a_ctl, r_b_ctl;
    logic [MAX_CIRCLES-1:0] r_a_mask, r_b_mask;
    logic [QW-1:0]          r_dx2 [MAX_CIRCLES];
    logic [QW-1:0]          r_dy2 [MAX_CIRCLES];
    logic [QW-1:0]          r_rsq [MAX_CIRCLES];
    logic                   r_hit [MAX_CIRCLES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else if (i_adv) begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_mask <= i_mask;
            r_b_mask <= r_a_mask;
        end
    end

    for (genvar i = 0; i < MAX_CIRCLES; i++) begin : g_lane
        logic [COORD_BITS-1:0] w_dx, w_dy;
        logic [QW:0]           w_d2;

        assign w_dx = (i_col >= i_cx[i]) ? i_col - i_cx[i] : i_cx[i] - i_col;
        assign w_dy = (i_row >= i_cy[i]) ? i_row - i_cy[i] : i_cy[i] - i_row;
        assign w_d2 = {1'b0, r_dx2[i]} + {1'b0, r_dy2[i]};

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_dx2[i] <= {{COORD_BITS{1'b0}}, w_dx} * {{COORD_BITS{1'b0}}, w_dx};
                r_dy2[i] <= {{COORD_BITS{1'b0}}, w_dy} * {{COORD_BITS{1'b0}}, w_dy};
                r_rsq[i] <= i_rsq[i];
                r_hit[i] <= r_a_mask[i] && (w_d2 < {1'b0, r_rsq[i]});
            end
        end
        assign o_hit[i] = r_hit[i];
    end

    assign o_ctl  = r_b_ctl;
    assign o_mask = r_b_mask;

endmodule

>>> sv/dcs_accum.sv
// dcs_accum: saturating per-circle sums and the end-of-region snapshot.
// Depends on dcs_pkg.
`timescale 1ns / 1ps

module dcs_accum import dcs_pkg::*; #(
    parameter int MAX_CIRCLES = MAX_CIRCLES_DEF,
    parameter int SUM_BITS    = SUM_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  t_pix_ctl               i_ctl,
    input  logic [MAX_CIRCLES-1:0] i_mask,
    input  logic                   i_hit     [MAX_CIRCLES],
    output logic                   o_fin_valid,
    output logic [MAX_CIRCLES-1:0] o_fin_mask,
    output logic [SUM_BITS-1:0]    o_fin_sum [MAX_CIRCLES]
);

    logic [SUM_BITS-1:0]    r_sum     [MAX_CIRCLES];
    logic [SUM_BITS-1:0]    n_sum     [MAX_CIRCLES];
    logic [SUM_BITS-1:0]    r_fin_sum [MAX_CIRCLES];
    logic [MAX_CIRCLES-1:0] r_fin_mask;
    logic                   r_fin_valid;
    logic                   w_step, w_end, w_sums_zero;

    assign w_step = i_adv && i_ctl.valid;
    assign w_end  = w_step && i_ctl.last;

    for (genvar i = 0; i < MAX_CIRCLES; i++) begin : g_sum
        logic [SUM_BITS:0] w_add;

        assign w_add    = {1'b0, r_sum[i]}
                        + (i_hit[i] ? (SUM_BITS+1)'(i_ctl.pix) : '0);
        // saturate at all ones
        assign n_sum[i] = w_add[SUM_BITS] ? '1 : w_add[SUM_BITS-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sum[i] <= '0;
            end else if (w_step) begin
                r_sum[i] <= i_ctl.last ? '0 : n_sum[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_end) begin
                r_fin_sum[i] <= n_sum[i];
            end
        end
        assign o_fin_sum[i] = r_fin_sum[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (i_adv) begin
            r_fin_valid <= w_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_fin_mask <= i_mask;
        end
    end

    always_comb begin
        w_sums_zero = 1'b1;
        for (int i = 0; i < MAX_CIRCLES; i++) begin
            if (r_sum[i] != '0) begin
                w_sums_zero = 1'b0;
            end
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin_mask  = r_fin_mask;

`ifndef ASSERT_OFF
    a_end_snapshot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |=> (r_fin_valid && w_sums_zero))
        else $error("end of region did not snapshot and clear sums");
`endif

endmodule

>>> sv/dcs_pick.sv
// dcs_pick: minimum search over the snapshot sums and the result register.
// Depends on dcs_pkg.
`timescale 1ns / 1ps

module dcs_pick import dcs_pkg::*; #(
    parameter int MAX_CIRCLES = MAX_CIRCLES_DEF,
    parameter int SUM_BITS    = SUM_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fin_valid,
    input  logic [MAX_CIRCLES-1:0] i_fin_mask,
    input  logic [SUM_BITS-1:0]    i_fin_sum [MAX_CIRCLES],
    input  logic                   i_m_ready,
    output logic                   o_m_valid,
    output logic [SLOT_BITS-1:0]   o_slot,
    output logic [SUM_BITS-1:0]    o_sum,
    output logic                   o_none,
    output logic                   o_stall
);

    localparam int LV    = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 0;
    localparam int NP    = 1 << LV;
    localparam int NODES = 2 * NP - 1;
    localparam int IB    = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;

    logic                lf_v   [NP];
    logic [IB-1:0]       lf_idx [NP];
    logic [SUM_BITS-1:0] lf_sum [NP];
    logic                tr_v   [NODES];
    logic [IB-1:0]       tr_idx [NODES];
    logic [SUM_BITS-1:0] tr_sum [NODES];

    logic                r_out_valid;
    logic [SLOT_BITS-1:0] r_out_slot;
    logic [SUM_BITS-1:0] r_out_sum;
    logic                r_out_none;
    logic                w_load;

    for (genvar i = 0; i < NP; i++) begin : g_leaf
        if (i < MAX_CIRCLES) begin : g_real
            assign lf_v[i]   = i_fin_mask[i];
            assign lf_idx[i] = IB'(i);
            assign lf_sum[i] = i_fin_sum[i];
        end else begin : g_pad
            assign lf_v[i]   = 1'b0;
            assign lf_idx[i] = '0;
            assign lf_sum[i] = '0;
        end
    end

    // heap-ordered tree; left child holds lower slots, so ties keep it
    always_comb begin
        for (int i = 0; i < NP; i++) begin
            tr_v[NP-1+i]   = lf_v[i];
            tr_idx[NP-1+i] = lf_idx[i];
            tr_sum[NP-1+i] = lf_sum[i];
        end
        for (int k = NP - 2; k >= 0; k--) begin
            if (tr_v[2*k+2] && (!tr_v[2*k+1] || tr_sum[2*k+2] < tr_sum[2*k+1])) begin
                tr_v[k]   = 1'b1;
                tr_idx[k] = tr_idx[2*k+2];
                tr_sum[k] = tr_sum[2*k+2];
            end else begin
                tr_v[k]   = tr_v[2*k+1];
                tr_idx[k] = tr_idx[2*k+1];
                tr_sum[k] = tr_sum[2*k+1];
            end
        end
    end

    assign o_stall = i_fin_valid && r_out_valid && !i_m_ready;
    assign w_load  = i_fin_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_none <= !tr_v[0];
            r_out_slot <= tr_v[0] ? SLOT_BITS'(tr_idx[0]) : '0;
            r_out_sum  <= tr_v[0] ? tr_sum[0] : '0;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_slot    = r_out_slot;
    assign o_sum     = r_out_sum;
    assign o_none    = r_out_none;

`ifndef ASSERT_OFF
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_none) |-> (r_out_slot == '0 && r_out_sum == '0))
        else $error("empty result carries nonzero fields");
    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fin_valid && r_out_valid && i_m_ready) |=> r_out_valid)
        else $error("pending result not moved into output register");
`endif

endmodule

>>> sv/darkest_circle_select.sv
// darkest_circle_select: top level; picks the darkest of the loaded circles.
// Result path: input stage, squares, inside test, snapshot, result register.
// Throughput: one beat per cycle, loads and pixels alike; input stalls only when a
//   result is held in the output register, another is ready and tready is low.
// Reset: synchronous, active low; clears counters, loaded flags, sums and valids,
//   row width back to 1024. The circle table itself is not cleared.
`timescale 1ns / 1ps

module darkest_circle_select import dcs_pkg::*; #(
    parameter int MAX_CIRCLES = MAX_CIRCLES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int SUM_BITS    = SUM_BITS_DEF,
    localparam int IN_W  = ((SLOT_BITS + 3 * COORD_BITS + PIX_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((SLOT_BITS + SUM_BITS + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // circle_slot, center_x, center_y, radius, gray level, zero pad
    input  logic [IN_W-1:0]    s_axis_tdata,
    // op: load circle or pixel
    input  logic               s_axis_tuser,
    // last_pixel
    input  logic               s_axis_tlast,
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // best_slot, best_sum, zero pad
    output logic [OUT_W-1:0]   m_axis_tdata,
    // no_circle
    output logic               m_axis_tuser,
    // row width register write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [RW_BITS-1:0] i_cfg_data
);

    // field positions inside s_axis_tdata
    localparam int CX_LSB  = SLOT_BITS;
    localparam int CY_LSB  = CX_LSB + COORD_BITS;
    localparam int RAD_LSB = CY_LSB + COORD_BITS;
    localparam int PIX_LSB = RAD_LSB + COORD_BITS;

    logic                    w_adv, w_stall;

    // input stage -> distance lanes
    t_pix_ctl                w_s1_ctl;
    logic [MAX_CIRCLES-1:0]  w_s1_mask;
    logic [COORD_BITS-1:0]   w_s1_col, w_s1_row;
    logic [COORD_BITS-1:0]   w_cx  [MAX_CIRCLES];
    logic [COORD_BITS-1:0]   w_cy  [MAX_CIRCLES];
    logic [2*COORD_BITS-1:0] w_rsq [MAX_CIRCLES];

    // distance lanes -> accumulators
    t_pix_ctl                w_b_ctl;
    logic [MAX_CIRCLES-1:0]  w_b_mask;
    logic                    w_hit [MAX_CIRCLES];

    // accumulators -> min search
    logic                    w_fin_valid;
    logic [MAX_CIRCLES-1:0]  w_fin_mask;
    logic [SUM_BITS-1:0]     w_fin_sum [MAX_CIRCLES];

    logic [SLOT_BITS-1:0]    w_slot;
    logic [SUM_BITS-1:0]     w_sum;

    // The whole pipe moves together; it only holds while a result waits in
    // the output register, the snapshot stage behind it is full and tready is low.
    assign w_adv         = !w_stall;
    assign s_axis_tready = w_adv;
    // row width can be written any cycle
    assign o_cfg_ready   = 1'b1;

    // Front: circle table written at the load beat, so a pixel right behind
    // a load already sees the new circle; raster counters and the loaded set
    // are captured with each pixel and cleared by the last pixel.
    dcs_front #(
        .MAX_CIRCLES (MAX_CIRCLES),
        .COORD_BITS  (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (s_axis_tvalid),
        .i_op        (s_axis_tuser),
        .i_slot      (s_axis_tdata[SLOT_BITS-1:0]),
        .i_cx        (s_axis_tdata[CX_LSB +: COORD_BITS]),
        .i_cy        (s_axis_tdata[CY_LSB +: COORD_BITS]),
        .i_rad       (s_axis_tdata[RAD_LSB +: COORD_BITS]),
        .i_pix       (s_axis_tdata[PIX_LSB +: PIX_BITS]),
        .i_last      (s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_ctl       (w_s1_ctl),
        .o_mask      (w_s1_mask),
        .o_col       (w_s1_col),
        .o_row       (w_s1_row),
        .o_cx        (w_cx),
        .o_cy        (w_cy),
        .o_rsq       (w_rsq)
    );

    // One lane per circle: squared distances, then strict inside test.
    dcs_dist #(
        .MAX_CIRCLES (MAX_CIRCLES),
        .COORD_BITS  (COORD_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_ctl   (w_s1_ctl),
        .i_mask  (w_s1_mask),
        .i_col   (w_s1_col),
        .i_row   (w_s1_row),
        .i_cx    (w_cx),
        .i_cy    (w_cy),
        .i_rsq   (w_rsq),
        .o_ctl   (w_b_ctl),
        .o_mask  (w_b_mask),
        .o_hit   (w_hit)
    );

    // Saturating sums; the last pixel's totals go to a snapshot bank so the
    // next region can start accumulating right behind the last pixel.
    dcs_accum #(
        .MAX_CIRCLES (MAX_CIRCLES),
        .SUM_BITS    (SUM_BITS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_ctl       (w_b_ctl),
        .i_mask      (w_b_mask),
        .i_hit       (w_hit),
        .o_fin_valid (w_fin_valid),
        .o_fin_mask  (w_fin_mask),
        .o_fin_sum   (w_fin_sum)
    );

    // Min tree over the snapshot, lowest slot wins ties, into the result reg.
    dcs_pick #(
        .MAX_CIRCLES (MAX_CIRCLES),
        .SUM_BITS    (SUM_BITS)
    ) u_pick (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (w_fin_valid),
        .i_fin_mask  (w_fin_mask),
        .i_fin_sum   (w_fin_sum),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_slot      (w_slot),
        .o_sum       (w_sum),
        .o_none      (m_axis_tuser),
        .o_stall     (w_stall)
    );

    assign m_axis_tdata = OUT_W'({w_sum, w_slot});

endmodule
